FILE: sv/baa_pkg.sv
// ----------------------------------------------------------------------------
// baa_pkg: shared types and constants of the bump arena allocator
// Field widths, command and register codes, and the saturating address add.
// ----------------------------------------------------------------------------
package baa_pkg;

	// Field widths.
	localparam int ADDR_W       = 32;
	localparam int REQ_W        = 24;
	localparam int BLK_W        = 25;
	localparam int CNT_W        = 32;
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 24;

	// Arena constants.
	localparam int HEADER_BYTES = 8;
	localparam int ALIGN_BITS   = 2;
	localparam logic [REQ_W-1:0] MIN_PAYLOAD_RST = REQ_W'(12248);

	// Command codes.
	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} cmd_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TRACK_STATS = 1'b0,
		CFG_MIN_PAYLOAD = 1'b1
	} cfg_reg_t;

	// One accepted request.
	typedef struct packed {
		cmd_t              command;
		logic [REQ_W-1:0]  request_size;
		logic [ADDR_W-1:0] free_address;
		logic [ADDR_W-1:0] new_block_base;
	} req_item_t;

	// One result.
	typedef struct packed {
		logic [ADDR_W-1:0] result_address;
		logic              grew;
		logic [BLK_W-1:0]  new_block_bytes;
		logic              rolled_back;
		logic [ADDR_W-1:0] clear_length;
		logic [CNT_W-1:0]  reuse_total;
		logic [CNT_W-1:0]  reuse_byte_total;
		logic [CNT_W-1:0]  free_total;
		logic [CNT_W-1:0]  free_byte_total;
		logic [ADDR_W-1:0] high_water_mark;
	} rsp_item_t;

	// Address plus a byte count, clamped at the top of the address space.
	function automatic logic [ADDR_W-1:0] sat_add(input logic [ADDR_W-1:0] a,
			input logic [BLK_W-1:0] b);
		logic [ADDR_W:0] sum;
		sum = {1'b0, a} + (ADDR_W+1)'(b);
		return sum[ADDR_W] ? {ADDR_W{1'b1}} : sum[ADDR_W-1:0];
	endfunction

endpackage

FILE: sv/baa_req_if.sv
// ----------------------------------------------------------------------------
// baa_req_if: request channel of the bump arena allocator
// Valid/ready handshake carrying one allocate or free command.
// ----------------------------------------------------------------------------
interface baa_req_if;
	logic                       valid;
	logic                       ready;
	baa_pkg::cmd_t              command;
	logic [baa_pkg::REQ_W-1:0]  request_size;
	logic [baa_pkg::ADDR_W-1:0] free_address;
	logic [baa_pkg::ADDR_W-1:0] new_block_base;

	modport source (output valid, command, request_size, free_address, new_block_base,
		input ready);
	modport sink (input valid, command, request_size, free_address, new_block_base,
		output ready);
endinterface

FILE: sv/baa_rsp_if.sv
// ----------------------------------------------------------------------------
// baa_rsp_if: result channel of the bump arena allocator
// Valid/ready handshake carrying one result and the statistics snapshot.
// ----------------------------------------------------------------------------
interface baa_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [baa_pkg::ADDR_W-1:0] result_address;
	logic                       grew;
	logic [baa_pkg::BLK_W-1:0]  new_block_bytes;
	logic                       rolled_back;
	logic [baa_pkg::ADDR_W-1:0] clear_length;
	logic [baa_pkg::CNT_W-1:0]  reuse_total;
	logic [baa_pkg::CNT_W-1:0]  reuse_byte_total;
	logic [baa_pkg::CNT_W-1:0]  free_total;
	logic [baa_pkg::CNT_W-1:0]  free_byte_total;
	logic [baa_pkg::ADDR_W-1:0] high_water_mark;

	modport source (output valid, result_address, grew, new_block_bytes, rolled_back,
		clear_length, reuse_total, reuse_byte_total, free_total, free_byte_total,
		high_water_mark, input ready);
	modport sink (input valid, result_address, grew, new_block_bytes, rolled_back,
		clear_length, reuse_total, reuse_byte_total, free_total, free_byte_total,
		high_water_mark, output ready);
endinterface

FILE: sv/baa_cfg_if.sv
// ----------------------------------------------------------------------------
// baa_cfg_if: configuration write channel of the bump arena allocator
// Valid/ready handshake carrying a register index and write data.
// ----------------------------------------------------------------------------
interface baa_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [baa_pkg::CFG_IDX_W-1:0]  reg_index;
	logic [baa_pkg::CFG_DATA_W-1:0] wdata;

	modport source (output valid, reg_index, wdata, input ready);
	modport sink (input valid, reg_index, wdata, output ready);
endinterface

FILE: sv/bump_arena_allocator_with_lifo_free.sv
// ----------------------------------------------------------------------------
// bump_arena_allocator_with_lifo_free: bump-pointer arena with LIFO free
// Allocates 4-byte aligned chunks from the current block, opens a new block
// when a request does not fit; with stats on, free rolls back the last alloc.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Carries
//   cfg      in         register index and write data
//   req      in         command, request size, free address, new block base
//   rsp      out        result address, block growth, rollback, statistics
//
// One request per cycle is sustained while the result channel is ready. A
// request is captured in the input register and processed in a single pass
// of adds and compares against the arena registers into the result register.
// A stalled result register holds its request back; the input register still
// takes one more request. Reset clears all arena state and counters, and the
// block is ready right after reset.
module bump_arena_allocator_with_lifo_free (
	input  logic clk,
	input  logic arst_n,
	baa_cfg_if.sink   cfg,
	baa_req_if.sink   req,
	baa_rsp_if.source rsp
);

	// Configuration registers.
	logic                          track_stats_q;
	logic [baa_pkg::REQ_W-1:0]     min_payload_q;

	// Arena state.
	logic [baa_pkg::ADDR_W-1:0]    bump_q, block_end_q, last_alloc_q, high_water_q;
	logic [baa_pkg::CNT_W-1:0]     reuse_cnt_q, reuse_bytes_q, free_cnt_q, freed_bytes_q;

	// Pipeline registers.
	logic                          valid_s1;
	baa_pkg::req_item_t            item_s1;
	logic                          rsp_valid_q;
	baa_pkg::rsp_item_t            rsp_q;

	// Next arena state and result.
	logic [baa_pkg::ADDR_W-1:0]    bump_d, block_end_d, last_alloc_d, high_water_d;
	logic [baa_pkg::CNT_W-1:0]     reuse_cnt_d, reuse_bytes_d, free_cnt_d, freed_bytes_d;
	baa_pkg::rsp_item_t            rsp_d;

	// Datapath intermediates.
	logic [baa_pkg::BLK_W-1:0]     size_sum, size, payload, block_bytes;
	logic [baa_pkg::BLK_W:0]       block_sum;
	logic [baa_pkg::ADDR_W:0]      fit_end;
	logic                          fits;
	logic [baa_pkg::ADDR_W-1:0]    base_bump, base_end, alloc, next_ptr, gap, reused;
	logic [baa_pkg::ADDR_W-1:0]    free_len;
	logic                          advance, req_fire;

	// Handshakes.
	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;
	assign req_fire  = req.valid && req.ready;
	assign cfg.ready = 1'b1;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			track_stats_q <= 1'b0;
			min_payload_q <= baa_pkg::MIN_PAYLOAD_RST;
		end else if (cfg.valid) begin
			case (baa_pkg::cfg_reg_t'(cfg.reg_index))
				baa_pkg::CFG_TRACK_STATS: track_stats_q <= cfg.wdata[0];
				baa_pkg::CFG_MIN_PAYLOAD: min_payload_q <= cfg.wdata[baa_pkg::REQ_W-1:0];
				default: ;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			item_s1.command        <= req.command;
			item_s1.request_size   <= req.request_size;
			item_s1.free_address   <= req.free_address;
			item_s1.new_block_base <= req.new_block_base;
		end
	end

	// Allocation sizing: round up to four bytes and size a possible new block.
	always_comb begin
		size_sum    = {1'b0, item_s1.request_size} +
			baa_pkg::BLK_W'((1 << baa_pkg::ALIGN_BITS) - 1);
		size        = {size_sum[baa_pkg::BLK_W-1:baa_pkg::ALIGN_BITS],
			{baa_pkg::ALIGN_BITS{1'b0}}};
		payload     = (size > {1'b0, min_payload_q}) ? size : {1'b0, min_payload_q};
		block_sum   = {1'b0, payload} + (baa_pkg::BLK_W+1)'(baa_pkg::HEADER_BYTES);
		block_bytes = block_sum[baa_pkg::BLK_W-1:0];
		fit_end     = {1'b0, bump_q} + (baa_pkg::ADDR_W+1)'(size);
		fits        = fit_end <= {1'b0, block_end_q};
		base_bump   = baa_pkg::sat_add(item_s1.new_block_base,
			baa_pkg::BLK_W'(baa_pkg::HEADER_BYTES));
		base_end    = baa_pkg::sat_add(item_s1.new_block_base, block_bytes);
	end

	// Command processing and next arena state.
	always_comb begin
		alloc    = fits ? bump_q : base_bump;
		next_ptr = baa_pkg::sat_add(alloc, size);
		gap      = high_water_q - alloc;
		reused   = (baa_pkg::ADDR_W'(size) >= gap) ? gap : baa_pkg::ADDR_W'(size);
		free_len = bump_q - last_alloc_q;

		bump_d        = bump_q;
		block_end_d   = block_end_q;
		last_alloc_d  = last_alloc_q;
		high_water_d  = high_water_q;
		reuse_cnt_d   = reuse_cnt_q;
		reuse_bytes_d = reuse_bytes_q;
		free_cnt_d    = free_cnt_q;
		freed_bytes_d = freed_bytes_q;

		rsp_d                 = '0;
		rsp_d.result_address  = item_s1.free_address;

		case (item_s1.command)
			baa_pkg::CMD_ALLOC: begin
				rsp_d.result_address = alloc;
				if (!fits) begin
					block_end_d           = base_end;
					rsp_d.grew            = 1'b1;
					rsp_d.new_block_bytes = block_bytes;
				end
				last_alloc_d = alloc;
				bump_d       = next_ptr;
				if (high_water_q < next_ptr) begin
					high_water_d = next_ptr;
				end
				// Reuse counts allocations starting below the high-water mark.
				if (track_stats_q && (alloc < high_water_q)) begin
					reuse_cnt_d   = reuse_cnt_q + baa_pkg::CNT_W'(1);
					reuse_bytes_d = reuse_bytes_q + baa_pkg::CNT_W'(reused);
				end
			end
			baa_pkg::CMD_FREE: begin
				// Only the most recent allocation can be rolled back.
				if (track_stats_q && (item_s1.free_address == last_alloc_q)) begin
					bump_d             = last_alloc_q;
					free_cnt_d         = free_cnt_q + baa_pkg::CNT_W'(1);
					freed_bytes_d      = freed_bytes_q + baa_pkg::CNT_W'(free_len);
					rsp_d.rolled_back  = 1'b1;
					rsp_d.clear_length = free_len;
				end
			end
			default: ;
		endcase

		rsp_d.reuse_total      = reuse_cnt_d;
		rsp_d.reuse_byte_total = reuse_bytes_d;
		rsp_d.free_total       = free_cnt_d;
		rsp_d.free_byte_total  = freed_bytes_d;
		rsp_d.high_water_mark  = high_water_d;
	end

	// Arena state update, one request per advance.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bump_q        <= '0;
			block_end_q   <= '0;
			last_alloc_q  <= '0;
			high_water_q  <= '0;
			reuse_cnt_q   <= '0;
			reuse_bytes_q <= '0;
			free_cnt_q    <= '0;
			freed_bytes_q <= '0;
		end else if (advance) begin
			bump_q        <= bump_d;
			block_end_q   <= block_end_d;
			last_alloc_q  <= last_alloc_d;
			high_water_q  <= high_water_d;
			reuse_cnt_q   <= reuse_cnt_d;
			reuse_bytes_q <= reuse_bytes_d;
			free_cnt_q    <= free_cnt_d;
			freed_bytes_q <= freed_bytes_d;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= rsp_d;
		end
	end

	// Result channel outputs.
	assign rsp.valid            = rsp_valid_q;
	assign rsp.result_address   = rsp_q.result_address;
	assign rsp.grew             = rsp_q.grew;
	assign rsp.new_block_bytes  = rsp_q.new_block_bytes;
	assign rsp.rolled_back      = rsp_q.rolled_back;
	assign rsp.clear_length     = rsp_q.clear_length;
	assign rsp.reuse_total      = rsp_q.reuse_total;
	assign rsp.reuse_byte_total = rsp_q.reuse_byte_total;
	assign rsp.free_total       = rsp_q.free_total;
	assign rsp.free_byte_total  = rsp_q.free_byte_total;
	assign rsp.high_water_mark  = rsp_q.high_water_mark;

endmodule

FILE: sv/baa_checker.sv
// ----------------------------------------------------------------------------
// baa_checker: port-level checks of the bump arena allocator
// Watches the result channel for handshake hold and field consistency.
// ----------------------------------------------------------------------------
module baa_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       rsp_valid,
	input logic                       rsp_ready,
	input logic [baa_pkg::ADDR_W-1:0] rsp_result_address,
	input logic                       rsp_grew,
	input logic [baa_pkg::BLK_W-1:0]  rsp_new_block_bytes,
	input logic                       rsp_rolled_back,
	input logic [baa_pkg::ADDR_W-1:0] rsp_clear_length
);

	// A stalled result stays offered.
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result valid dropped while stalled");

	// A stalled result keeps its address.
	a_addr_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_result_address))
		else $error("result address changed while stalled");

	// A rollback never comes with a new block.
	a_roll_no_grow: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_rolled_back |-> !rsp_grew && (rsp_new_block_bytes == '0))
		else $error("rollback reported together with block growth");

	// A new block always includes its header and never reports a clear.
	a_grow_size: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_grew |->
			(rsp_new_block_bytes >= baa_pkg::BLK_W'(baa_pkg::HEADER_BYTES)) &&
			!rsp_rolled_back && (rsp_clear_length == '0))
		else $error("new block size or clear length inconsistent");

	// Without growth the block size field is zero.
	a_no_grow_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_grew |-> rsp_new_block_bytes == '0)
		else $error("block size reported without growth");

endmodule

bind bump_arena_allocator_with_lifo_free baa_checker u_baa_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.rsp_valid           (rsp.valid),
	.rsp_ready           (rsp.ready),
	.rsp_result_address  (rsp.result_address),
	.rsp_grew            (rsp.grew),
	.rsp_new_block_bytes (rsp.new_block_bytes),
	.rsp_rolled_back     (rsp.rolled_back),
	.rsp_clear_length    (rsp.clear_length)
);
